// ----- rtl/wpc_pkg.sv -----
// shared types, constants and the arctangent table for the waypoint heading controller
package wpc_pkg;

  // default iteration count of the bearing cordic
  localparam int CORDIC_STEPS_DEF = 16;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_LAT  = 3'd0;
  localparam logic [2:0] REG_TARGET_LON  = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN   = 3'd2;
  localparam logic [2:0] REG_INT_GAIN    = 3'd3;
  localparam logic [2:0] REG_MASS_GAIN   = 3'd4;
  localparam logic [2:0] REG_CAL_TILT    = 3'd5;
  localparam logic [2:0] REG_CAL_ENABLE  = 3'd6;
  localparam logic [2:0] REG_AUTO_MODE   = 3'd7;

  // angle and limit constants
  localparam logic signed [25:0] Z_QUARTER   = 26'sd5898240;  // 90 deg in 1/65536 deg
  localparam logic signed [19:0] DEG_90      = 20'sd11520;
  localparam logic signed [19:0] DEG_450     = 20'sd57600;
  localparam logic signed [19:0] DEG_180     = 20'sd23040;
  localparam logic signed [19:0] DEG_360     = 20'sd46080;
  localparam int                 TILT_LIM    = 6400;
  localparam int                 MASS_LIM    = 12800;
  localparam logic [15:0]        SPEED_ONE   = 16'd256;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CORDIC,
    S_ANGLE,
    S_MUL_P,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_PE,
    S_TILT,
    S_MUL_M,
    S_MASS,
    S_DONE
  } wpc_state_t;

  // rounded atan(2^-i) in 1/65536 deg
  function automatic logic [22:0] atan_entry(input logic [4:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/waypoint_heading_pi_mass_control.sv -----
// waypoint heading pi controller with cordic bearing and ballast mass setpoint
// a new word is accepted only in the idle state, once the previous word is finished,
//   so the word rate is set by the cordic iteration loop
//   and the single shared 39x25 multiplier used five times per word
// manual mode words are accepted and give no result
// reset (synchronous, active low) restores register defaults, clears integrator and tick
module waypoint_heading_pi_mass_control import wpc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [29:0] in_latitude,
  input  logic signed [30:0] in_longitude,
  input  logic [15:0]        in_ground_course,
  input  logic [15:0]        in_yaw_heading,
  input  logic [15:0]        in_ground_speed,
  input  logic signed [15:0] in_roll_angle,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_mass_position,
  output logic signed [13:0] out_desired_tilt,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

  // configuration registers
  logic signed [29:0] tlat_r;
  logic signed [30:0] tlon_r;
  logic signed [23:0] pgain_r, igain_r, mgain_r;
  logic signed [15:0] cal_tilt_r;
  logic               cal_en_r, auto_r;

  // control state
  wpc_state_t state_r, state_nxt;
  logic [IW-1:0] step_r;
  logic          out_valid_r;
  logic signed [13:0] integ_r, integ_nxt;
  logic [31:0]   last_tick_r;

  // payload registers
  logic signed [34:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [25:0] z_r, z_nxt;
  logic               zero_r;
  logic [15:0]        heading_r;
  logic signed [15:0] roll_r;
  logic [31:0]        now_r, dt_r;
  logic signed [19:0] err_r, err_nxt;
  logic signed [63:0] prod_r;
  logic [37:0]        mag_r;
  logic               pneg_r;
  logic [63:0]        lo_r;
  logic [60:0]        term_r;
  logic signed [13:0] tilt_r, tilt_nxt;
  logic signed [14:0] mass_r, mass_nxt;
  logic signed [14:0] out_mass_r;
  logic signed [13:0] out_tilt_r;

  // combinational helpers
  logic               in_acc;
  logic signed [31:0] dx;
  logic signed [30:0] dy;
  logic signed [34:0] sh_x, sh_y;
  logic signed [25:0] atan_v, zr;
  logic signed [16:0] ang;
  logic signed [19:0] bearing, err_raw;
  logic signed [20:0] integ_sum;
  logic signed [38:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [63:0] p_abs;
  logic [71:0]        full_prod;
  logic signed [63:0] sum, term_s;
  logic signed [47:0] sum_sh;
  logic signed [16:0] diff;
  logic signed [47:0] mass_sh;
  logic               out_free;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_mass_position = out_mass_r;
  assign out_desired_tilt  = out_tilt_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc && auto_r) state_nxt = S_CORDIC;
      S_CORDIC: if (step_r == LAST_STEP) state_nxt = S_ANGLE;
      S_ANGLE:  state_nxt = S_MUL_P;
      S_MUL_P:  state_nxt = S_MUL_LO;
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_MUL_PE;
      S_MUL_PE: state_nxt = S_TILT;
      S_TILT:   state_nxt = S_MUL_M;
      S_MUL_M:  state_nxt = S_MASS;
      S_MASS:   state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath: operand setup, cordic step, error and saturation logic
  always_comb begin
    dx = 32'(tlon_r) - 32'(in_longitude);
    dy = 31'(tlat_r) - 31'(in_latitude);
    if (state_r == S_IDLE) begin
      if (dx < 0) begin
        if (dy >= 0) begin
          x_nxt = 35'(dy);
          y_nxt = -35'(dx);
          z_nxt = Z_QUARTER;
        end else begin
          x_nxt = -35'(dy);
          y_nxt = 35'(dx);
          z_nxt = -Z_QUARTER;
        end
      end else begin
        x_nxt = 35'(dx);
        y_nxt = 35'(dy);
        z_nxt = '0;
      end
    end else begin
      x_nxt = x_r;
      y_nxt = y_r;
      z_nxt = z_r;
    end

    // one shared cordic micro-rotation
    sh_x   = x_r >>> step_r;
    sh_y   = y_r >>> step_r;
    atan_v = 26'(atan_entry(5'(step_r)));
    if (state_r == S_CORDIC) begin
      if (y_r >= 0) begin
        x_nxt = x_r + sh_y;
        y_nxt = y_r - sh_x;
        z_nxt = z_r + atan_v;
      end else begin
        x_nxt = x_r - sh_y;
        y_nxt = y_r + sh_x;
        z_nxt = z_r - atan_v;
      end
    end

    // bearing, heading error with one wrap, clamped integrator
    zr  = z_r + 26'sd256;
    ang = zero_r ? 17'sd0 : 17'(zr >>> 9);
    bearing = (20'(ang) <= DEG_90) ? DEG_90 - 20'(ang) : DEG_450 - 20'(ang);
    err_raw = bearing - 20'($signed({1'b0, heading_r}));
    if (err_raw > DEG_180)       err_nxt = err_raw - DEG_360;
    else if (err_raw < -DEG_180) err_nxt = err_raw + DEG_360;
    else                         err_nxt = err_raw;
    integ_sum = 21'(integ_r) + 21'(err_nxt);
    if (integ_sum > 21'(TILT_LIM))       integ_nxt = 14'(TILT_LIM);
    else if (integ_sum < -21'(TILT_LIM)) integ_nxt = -14'(TILT_LIM);
    else                                 integ_nxt = 14'(integ_sum);

    // shared multiplier operand select
    p_abs = prod_r[63] ? -prod_r : prod_r;
    diff  = cal_en_r ? 17'(cal_tilt_r) - 17'(roll_r) : 17'(tilt_r) - 17'(roll_r);
    case (state_r)
      S_MUL_P: begin
        mul_a = 39'(igain_r);
        mul_b = 25'(integ_r);
      end
      S_MUL_LO: begin
        mul_a = $signed({1'b0, p_abs[37:0]});
        mul_b = $signed({9'd0, dt_r[15:0]});
      end
      S_MUL_HI: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = $signed({9'd0, dt_r[31:16]});
      end
      S_MUL_PE: begin
        mul_a = 39'(pgain_r);
        mul_b = 25'(err_r);
      end
      S_MUL_M: begin
        mul_a = 39'(diff);
        mul_b = 25'(mgain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    // integral term magnitude, saturated at 2^60
    full_prod = 72'(lo_r) + {prod_r[55:0], 16'd0};

    // pi sum and tilt clamp
    term_s = pneg_r ? -$signed({3'd0, term_r}) : $signed({3'd0, term_r});
    sum    = prod_r + term_s;
    sum_sh = 48'(sum >>> 16);
    if (sum_sh > 48'(TILT_LIM))       tilt_nxt = 14'(TILT_LIM);
    else if (sum_sh < -48'(TILT_LIM)) tilt_nxt = -14'(TILT_LIM);
    else                              tilt_nxt = 14'(sum_sh);

    // mass setpoint clamp
    mass_sh = 48'(prod_r >>> 16);
    if (mass_sh > 48'(MASS_LIM))       mass_nxt = 15'(MASS_LIM);
    else if (mass_sh < -48'(MASS_LIM)) mass_nxt = -15'(MASS_LIM);
    else                               mass_nxt = 15'(mass_sh);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_tick_r <= '0;
      tlat_r      <= '0;
      tlon_r      <= '0;
      pgain_r     <= 24'sd32768;
      igain_r     <= 24'sd262;
      mgain_r     <= 24'sd262144;
      cal_tilt_r  <= '0;
      cal_en_r    <= 1'b0;
      auto_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CORDIC) step_r <= step_r + 1'b1;
      else                     step_r <= '0;
      if (state_r == S_ANGLE) begin
        integ_r     <= integ_nxt;
        last_tick_r <= now_r;
      end
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;
      // configuration write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_LAT: tlat_r     <= cfg_data[29:0];
          REG_TARGET_LON: tlon_r     <= cfg_data[30:0];
          REG_PROP_GAIN:  pgain_r    <= cfg_data[23:0];
          REG_INT_GAIN:   igain_r    <= cfg_data[23:0];
          REG_MASS_GAIN:  mgain_r    <= cfg_data[23:0];
          REG_CAL_TILT:   cal_tilt_r <= cfg_data[15:0];
          REG_CAL_ENABLE: cal_en_r   <= cfg_data[0];
          REG_AUTO_MODE:  auto_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      zero_r    <= (dx == 0) && (dy == 0);
      heading_r <= (in_ground_speed > SPEED_ONE) ? in_ground_course : in_yaw_heading;
      roll_r    <= in_roll_angle;
      now_r     <= in_now_ms;
    end
    if (state_r == S_ANGLE) begin
      err_r <= err_nxt;
      dt_r  <= now_r - last_tick_r;
    end
    if (state_r == S_MUL_LO) begin
      mag_r  <= p_abs[37:0];
      pneg_r <= prod_r[63];
    end
    if (state_r == S_MUL_HI) lo_r <= prod_r;
    if (state_r == S_MUL_PE) begin
      if (full_prod > 72'h10_0000_0000_0000_0000 >> 8)
        term_r <= {1'b1, 60'd0};
      else
        term_r <= full_prod[60:0];
    end
    if (state_r == S_TILT) tilt_r <= tilt_nxt;
    if (state_r == S_MASS) mass_r <= mass_nxt;
    if (state_r == S_DONE && out_free) begin
      out_mass_r <= mass_r;
      out_tilt_r <= tilt_r;
    end
  end

`ifndef SYNTHESIS
  // integrator never leaves its clamp range
  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= 14'sd6400) && (integ_r >= -14'sd6400))
    else $error("integrator out of range");

  // delivered tilt stays clamped
  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_desired_tilt <= 14'sd6400) && (out_desired_tilt >= -14'sd6400))
    else $error("desired tilt out of range");

  // delivered mass stays clamped
  a_mass_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mass_position <= 15'sd12800) && (out_mass_position >= -15'sd12800))
    else $error("mass setpoint out of range");

  // an automatic mode word starts the cordic
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && auto_r) |=> (state_r == S_CORDIC))
    else $error("word accepted without starting");

  // a result appears only out of the done state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_DONE))
    else $error("result without finished word");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the waypoint heading pi controller: scoreboard class and driving tasks
module tb_top;
  import wpc_pkg::*;

  // scoreboard: holds controller state and the queue of expected setpoint words
  class setpoint_board;
    longint tgt_lat, tgt_lon, kp, ki, km, cal_tilt;
    bit cal_en, auto_en;
    longint integ;
    bit [31:0] prev_tick;
    logic signed [14:0] mass_q[$];
    logic signed [13:0] tilt_q[$];
    int errors, checked;

    function new();
      tgt_lat = 0; tgt_lon = 0; kp = 32768; ki = 262; km = 262144; cal_tilt = 0;
      cal_en = 0; auto_en = 0; integ = 0; prev_tick = 0; errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [30:0] d);
      case (idx)
        REG_TARGET_LAT: tgt_lat = longint'($signed(d[29:0]));
        REG_TARGET_LON: tgt_lon = longint'($signed(d[30:0]));
        REG_PROP_GAIN:  kp = longint'($signed(d[23:0]));
        REG_INT_GAIN:   ki = longint'($signed(d[23:0]));
        REG_MASS_GAIN:  km = longint'($signed(d[23:0]));
        REG_CAL_TILT:   cal_tilt = longint'($signed(d[15:0]));
        REG_CAL_ENABLE: cal_en = d[0];
        REG_AUTO_MODE:  auto_en = d[0];
        default: ;
      endcase
    endfunction

    function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    function longint limit(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // vectoring cordic bearing angle in 1/128 deg
    function longint bearing_angle(longint dx, longint dy);
      longint x, y, z, t;
      x = dx; y = dy; z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (dx < 0) begin
        if (dy >= 0) begin x = dy; y = -dx; z = 90 * 65536; end
        else begin x = -dy; y = dx; z = -90 * 65536; end
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        t = x;
        if (y >= 0) begin
          x = x + (y >>> i); y = y - (t >>> i); z += atan_step(i);
        end else begin
          x = x - (y >>> i); y = y + (t >>> i); z -= atan_step(i);
        end
      end
      return (z + 256) >>> 9;
    endfunction

    function longint atan_step(int i);
      longint tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      return tab[i];
    endfunction

    // note an accepted tick
    function void note_tick(logic signed [29:0] lat, logic signed [30:0] lon,
                            logic [15:0] course, logic [15:0] yaw, logic [15:0] spd,
                            logic signed [15:0] roll, logic [31:0] now);
      longint a, brg, err, p, mag, term, sum, tilt, used, mass;
      longint unsigned dt, lim;
      if (!auto_en) return;
      lim = 64'd1 << 60;
      a = bearing_angle(tgt_lon - lon, tgt_lat - lat);
      brg = (a <= 11520) ? 11520 - a : 57600 - a;
      err = brg - ((spd > SPEED_ONE) ? longint'(course) : longint'(yaw));
      if (err > 23040) err -= 46080;
      else if (err < -23040) err += 46080;
      integ = limit(integ + err, TILT_LIM);
      dt = 64'(32'(now - prev_tick));
      prev_tick = now;
      p = ki * integ;
      mag = p < 0 ? -p : p;
      if (mag != 0 && dt > lim / longint'(mag)) term = lim;
      else term = mag * dt;
      if (p < 0) term = -term;
      sum = kp * err + term;
      tilt = limit(sum >>> 16, TILT_LIM);
      used = cal_en ? cal_tilt : tilt;
      mass = limit(((used - roll) * km) >>> 16, MASS_LIM);
      mass_q.push_back(15'(mass));
      tilt_q.push_back(14'(tilt));
    endfunction

    // compare one result word with the oldest expectation
    function void check_result(logic signed [14:0] m, logic signed [13:0] t);
      if (mass_q.size() == 0) begin
        $error("unexpected result word mass=%0d tilt=%0d", m, t);
        errors++;
        return;
      end
      checked++;
      if (mass_q[0] !== m) begin
        $error("mass_position expected %0d got %0d", mass_q[0], m); errors++;
      end
      if (tilt_q[0] !== t) begin
        $error("desired_tilt expected %0d got %0d", tilt_q[0], t); errors++;
      end
      void'(mass_q.pop_front());
      void'(tilt_q.pop_front());
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic signed [29:0] in_latitude = 0;
  logic signed [30:0] in_longitude = 0;
  logic [15:0] in_ground_course = 0, in_yaw_heading = 0, in_ground_speed = 0;
  logic signed [15:0] in_roll_angle = 0;
  logic [31:0] in_now_ms = 0;
  logic out_valid, out_ready = 0;
  logic signed [14:0] out_mass_position;
  logic signed [13:0] out_desired_tilt;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [30:0] cfg_data = 0;

  setpoint_board board = new();
  bit [31:0] tick_ms = 0;
  int ticks_sent = 0;
  int burst_left = 0;

  always #1 clk = ~clk;

  waypoint_heading_pi_mass_control DUT (.*);

  // receiver with its own stall pattern, quiet stretches included
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_mass_position, out_desired_tilt);
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 40) == 0);
    endcase
  end

  // one register write, after which the write channel is dropped to idle
  task automatic write_reg(logic [2:0] idx, logic [30:0] d);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected word, then the block's latency
  task automatic drain();
    while (board.mass_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_tick(logic signed [29:0] lat, logic signed [30:0] lon,
                           logic [15:0] course, logic [15:0] yaw, logic [15:0] spd,
                           logic signed [15:0] roll, logic [31:0] now);
    // bursts with random gaps
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1; in_latitude <= lat; in_longitude <= lon;
    in_ground_course <= course; in_yaw_heading <= yaw; in_ground_speed <= spd;
    in_roll_angle <= roll; in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_tick(lat, lon, course, yaw, spd, roll, now);
    ticks_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random tick: half of them near the waypoint, mostly with small elapsed times
  task automatic random_tick();
    logic signed [29:0] lat;
    logic signed [30:0] lon;
    logic [31:0] dt;
    case ($urandom_range(0, 3))
      0: begin lat = 30'($urandom); lon = 31'($urandom); end
      1: begin lat = 30'($signed($urandom_range(0, 754974720)) - 377487360);
         lon = 31'($signed($urandom_range(0, 1509949440)) - 754974720); end
      default: begin
        lat = 30'(board.tgt_lat + $signed($urandom_range(0, 20000)) - 10000);
        lon = 31'(board.tgt_lon + $signed($urandom_range(0, 20000)) - 10000);
      end
    endcase
    case ($urandom_range(0, 5))
      0: dt = $urandom;
      1: dt = 0;
      default: dt = $urandom_range(1, 300);
    endcase
    tick_ms += dt;
    send_tick(lat, lon,
      ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46080)),
      ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46080)),
      ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(200, 300)),
      ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 46080)) - 23040),
      tick_ms);
  endtask

  task automatic random_config(bit extreme);
    write_reg(REG_TARGET_LAT, extreme ? 31'($urandom_range(0,1) ? 377487360 : -377487360)
                                      : 31'($urandom));
    write_reg(REG_TARGET_LON, extreme ? 31'($urandom_range(0,1) ? 754974720 : -754974720)
                                      : 31'($urandom));
    write_reg(REG_PROP_GAIN, extreme ? 31'(24'h7FFFFF) : 31'($signed($urandom_range(0, 262144)) - 131072));
    write_reg(REG_INT_GAIN, extreme ? 31'(24'h800000) : 31'($signed($urandom_range(0, 4000)) - 2000));
    write_reg(REG_MASS_GAIN, extreme ? 31'(24'h800000) : 31'($urandom));
    write_reg(REG_CAL_TILT, extreme ? 31'(16'h8000) : 31'($urandom));
    write_reg(REG_CAL_ENABLE, 31'($urandom_range(0, 1)));
    write_reg(REG_AUTO_MODE, ($urandom_range(0, 7) == 0) ? 31'd0 : 31'd1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // manual mode ticks give nothing
    send_tick(30'sd1000, 31'sd2000, 16'd100, 16'd200, 16'd300, 16'sd5, 32'd10);
    idle_input();
    write_reg(REG_AUTO_MODE, 31'd1);
    // zero vector, quadrants, left half plane, speed threshold, error wrap
    send_tick(30'sd0, 31'sd0, 16'd0, 16'd0, 16'd256, 16'sd0, 32'd100);
    send_tick(30'sd0, 31'sd0, 16'd0, 16'd0, 16'd257, 16'sd0, 32'd200);
    send_tick(-30'sd1000, 31'sd0, 16'd46080, 16'd0, 16'd1000, 16'sd23040, 32'd300);
    send_tick(30'sd1000, 31'sd0, 16'd0, 16'd46080, 16'd0, -16'sd23040, 32'd400);
    send_tick(30'sd0, 31'sd5000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 32'd500);
    send_tick(30'sd0, -31'sd5000, 16'd0, 16'hFFFF, 16'd0, 16'sh8000, 32'hFFFF_FFFF);
    send_tick(30'sd377487360, 31'sd754974720, 16'd0, 16'd0, 16'd0, 16'sd0, 32'd3);
    send_tick(-30'sd377487360, -31'sd754974720, 16'd23040, 16'd23040, 16'd0, 16'sd0, 32'd3);
    send_tick(30'h1FFF_FFFF, 31'h3FFF_FFFF, 16'd0, 16'd0, 16'd0, 16'sd0, 32'h8000_0000);
    send_tick(30'h2000_0000, 31'h4000_0000, 16'd0, 16'd0, 16'd0, 16'sd0, 32'd1);
    idle_input();
    drain();
    // integral saturation: large gain and large elapsed time
    write_reg(REG_INT_GAIN, 31'(24'h7FFFFF));
    write_reg(REG_CAL_ENABLE, 31'd1);
    write_reg(REG_CAL_TILT, 31'(16'h7FFF));
    send_tick(30'sd0, -31'sd5000, 16'd0, 16'd40000, 16'd0, 16'sd0, 32'hF000_0000);
    send_tick(30'sd0, -31'sd5000, 16'd0, 16'd40000, 16'd0, 16'sd0, 32'h7000_0000);
    idle_input();
    drain();

    // random phases, extremes among the settings
    for (int ph = 0; ph < 12; ph++) begin
      random_config(ph % 4 == 1);
      tick_ms = board.prev_tick;
      repeat (130) random_tick();
      idle_input();
      drain();
    end

    $display("ran %0d ticks, %0d setpoint words checked over 12 register settings",
             ticks_sent, board.checked);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/wpc_pkg.sv
rtl/waypoint_heading_pi_mass_control.sv
tb/sv/tb_top.sv
